[rtl/core/aarr_pkg.sv]
package aarr_pkg;

    // Colors are 24-bit 0xBBGGRR words
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int CFG_IDX_W = 3;

    // Blend weights run from 0 to 256 inclusive
    localparam int             WGT_W   = 9;
    localparam logic [WGT_W-1:0] WGT_ONE = 9'd256;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_WIDTH     = 3'd0,
        REG_BOX_HEIGHT    = 3'd1,
        REG_CORNER_RADIUS = 3'd2,
        REG_FILL_COLOR    = 3'd3,
        REG_BORDER_COLOR  = 3'd4,
        REG_BACK_COLOR    = 3'd5
    } cfg_reg_t;

    // Per channel: (a*(256-n) + b*n) >> 8
    function automatic logic [COLOR_W-1:0] blend_rgb(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b,
        input logic [WGT_W-1:0]   n
    );
        logic [16:0]        acc;
        logic [COLOR_W-1:0] res;
        res = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 17'(a[ch*CHAN_W +: CHAN_W]) * 17'(WGT_ONE - n)
                + 17'(b[ch*CHAN_W +: CHAN_W]) * 17'(n);
            res[ch*CHAN_W +: CHAN_W] = acc[15:8];
        end
        return res;
    endfunction

endpackage

[rtl/core/aa_round_rect_pixel_shader.sv]
// Anti-aliased rounded-rectangle pixel shader. Each item is one pixel (col,
// row); the block returns one opaque ARGB word per pixel, blending the back,
// border and fill colors by the signed distance from the pixel center to the
// configured rounded box (8 fractional bits, floor integer square root). It
// takes one pixel per clock while the output buffer is not full. The pipeline
// has COORD_BITS+17 register stages and the two-entry output buffer holds
// two more results, so up to COORD_BITS+19 pixels can be in flight. out_valid
// for a result rises once it has passed the last pipeline register and been
// written into the output buffer. The square root resolves one result bit
// per pipeline stage. The output buffer lets input continue while one result
// waits; with both entries full the whole pipeline holds. Write configuration
// only while no pixel is in flight.
module aa_round_rect_pixel_shader #(
    parameter int COORD_BITS = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_write,
    input  logic [aarr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aarr_pkg::COLOR_W-1:0]    cfg_data,
    // pixel input
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [COORD_BITS-1:0]           col,
    input  logic [COORD_BITS-1:0]           row,
    // pixel output
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [31:0]                     pixel_word
);
    import aarr_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int HALF_W = C + 7;          // half side, Q.8
    localparam int POS_W  = C + 8;          // pixel center, Q.8
    localparam int Q_W    = C + 9;          // signed per-axis distance
    localparam int U_W    = C + 8;          // positive part of q
    localparam int SQ_W   = 2 * U_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int ROOT_W = U_W + 1;
    localparam int REM_W  = ROOT_W + 2;
    localparam int BASE_W = C + 10;
    localparam int SD_W   = C + 12;

    localparam int ST_ABS   = 0;
    localparam int ST_Q     = 1;
    localparam int ST_BASE  = 2;
    localparam int ST_SQ    = 3;
    localparam int ST_SUM   = 4;
    localparam int ST_ROOT0 = 5;
    localparam int ST_WGT   = ST_ROOT0 + ROOT_W;
    localparam int ST_MIX1  = ST_WGT + 1;
    localparam int ST_MIX2  = ST_WGT + 2;
    localparam int NST      = ST_MIX2 + 1;

    localparam logic signed [SD_W-1:0] OUT_OFS = SD_W'(128);
    localparam logic signed [SD_W-1:0] IN_OFS  = -SD_W'(128);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [C-1:0]       box_width_reg;
    logic [C-1:0]       box_height_reg;
    logic [C-1:0]       corner_radius_reg;
    logic [COLOR_W-1:0] fill_color_reg;
    logic [COLOR_W-1:0] border_color_reg;
    logic [COLOR_W-1:0] back_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_width_reg     <= C'(64);
            box_height_reg    <= C'(24);
            corner_radius_reg <= C'(4);
            fill_color_reg    <= '0;
            border_color_reg  <= '0;
            back_color_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_BOX_WIDTH:     box_width_reg     <= cfg_data[C-1:0];
                REG_BOX_HEIGHT:    box_height_reg    <= cfg_data[C-1:0];
                REG_CORNER_RADIUS: corner_radius_reg <= cfg_data[C-1:0];
                REG_FILL_COLOR:    fill_color_reg    <= cfg_data;
                REG_BORDER_COLOR:  border_color_reg  <= cfg_data;
                REG_BACK_COLOR:    back_color_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Box geometry from the registers: half sides, clamped radius, offsets
    logic [HALF_W-1:0] half_w, half_h, half_min, rad, off_x, off_y;
    logic [POS_W-1:0]  rad_full;

    always_comb
    begin
        half_w   = {box_width_reg, 7'b0};
        half_h   = {box_height_reg, 7'b0};
        rad_full = {corner_radius_reg, 8'b0};
        half_min = (half_w < half_h) ? half_w : half_h;
        rad      = (rad_full < {1'b0, half_min}) ? rad_full[HALF_W-1:0] : half_min;
        off_x    = half_w - rad;
        off_y    = half_h - rad;
    end

    // ------------------------------------------------------------------
    // Flow control: the whole pipe advances while the output buffer has room
    // ------------------------------------------------------------------
    logic [1:0]     cnt_reg, cnt_next;
    logic           adv, push, pop;
    logic [NST-1:0] vld_reg, vld_next;

    assign adv      = (cnt_reg != 2'd2);
    assign in_ready = adv;
    assign push     = adv && vld_reg[ST_MIX2];
    assign pop      = (cnt_reg != 2'd0) && out_ready;
    assign vld_next = {vld_reg[NST-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // ------------------------------------------------------------------
    // Stage 1: distance of the pixel center from the box center
    // ------------------------------------------------------------------
    logic [POS_W-1:0] px_reg, py_reg, px_next, py_next;
    logic [POS_W:0]   xc, yc, hwc, hhc;

    always_comb
    begin
        xc      = {1'b0, col, 8'h80};
        yc      = {1'b0, row, 8'h80};
        hwc     = (POS_W+1)'(half_w);
        hhc     = (POS_W+1)'(half_h);
        px_next = (xc >= hwc) ? POS_W'(xc - hwc) : POS_W'(hwc - xc);
        py_next = (yc >= hhc) ? POS_W'(yc - hhc) : POS_W'(hhc - yc);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: distance past the straight edges
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0] qx_reg, qy_reg, qx_next, qy_next;

    assign qx_next = $signed({1'b0, px_reg}) - $signed({2'b0, off_x});
    assign qy_next = $signed({1'b0, py_reg}) - $signed({2'b0, off_y});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg <= qx_next;
            qy_reg <= qy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: inside term minus radius, positive parts for the corner arc
    // ------------------------------------------------------------------
    logic signed [Q_W-1:0]    q_max, q_max_neg;
    logic signed [BASE_W-1:0] base3_reg, base3_next;
    logic [U_W-1:0]           ux_reg, uy_reg, ux_next, uy_next;

    always_comb
    begin
        q_max      = (qx_reg > qy_reg) ? qx_reg : qy_reg;
        q_max_neg  = q_max[Q_W-1] ? q_max : '0;
        base3_next = $signed({q_max_neg[Q_W-1], q_max_neg}) - $signed({3'b0, rad});
        ux_next    = qx_reg[Q_W-1] ? '0 : qx_reg[U_W-1:0];
        uy_next    = qy_reg[Q_W-1] ? '0 : qy_reg[U_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            base3_reg <= base3_next;
            ux_reg    <= ux_next;
            uy_reg    <= uy_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: squares; stage 5: sum of squares
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]          sqx_reg, sqy_reg;
    logic signed [BASE_W-1:0] base4_reg, base5_reg;
    logic [SUM_W-1:0]         sum_reg, sum_next;

    assign sum_next = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg   <= ux_reg * ux_reg;
            sqy_reg   <= uy_reg * uy_reg;
            base4_reg <= base3_reg;
            sum_reg   <= sum_next;
            base5_reg <= base4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, restoring digit recurrence
    // ------------------------------------------------------------------
    logic [2*ROOT_W-1:0]      rt_v_reg    [ROOT_W];
    logic [REM_W-1:0]         rt_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]        rt_root_reg [ROOT_W];
    logic signed [BASE_W-1:0] rt_base_reg [ROOT_W];
    logic [2*ROOT_W-1:0]      rt_v_next    [ROOT_W];
    logic [REM_W-1:0]         rt_rem_next  [ROOT_W];
    logic [ROOT_W-1:0]        rt_root_next [ROOT_W];
    logic signed [BASE_W-1:0] rt_base_next [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_root
            logic [2*ROOT_W-1:0]      v_in;
            logic [REM_W-1:0]         rem_in, rem_sh, trial;
            logic [ROOT_W-1:0]        root_in;
            logic signed [BASE_W-1:0] base_in;

            if (k == 0)
            begin : g_first
                assign v_in    = {1'b0, sum_reg};
                assign rem_in  = '0;
                assign root_in = '0;
                assign base_in = base5_reg;
            end
            else
            begin : g_rest
                assign v_in    = rt_v_reg[k-1];
                assign rem_in  = rt_rem_reg[k-1];
                assign root_in = rt_root_reg[k-1];
                assign base_in = rt_base_reg[k-1];
            end

            // bring down the next two bits and try root*4+1
            assign rem_sh          = {rem_in[REM_W-3:0], v_in[2*ROOT_W-1 -: 2]};
            assign trial           = {root_in, 2'b01};
            assign rt_v_next[k]    = v_in << 2;
            assign rt_rem_next[k]  = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
            assign rt_root_next[k] = {root_in[ROOT_W-2:0], rem_sh >= trial};
            assign rt_base_next[k] = base_in;
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < ROOT_W; i++)
            begin
                rt_v_reg[i]    <= rt_v_next[i];
                rt_rem_reg[i]  <= rt_rem_next[i];
                rt_root_reg[i] <= rt_root_next[i];
                rt_base_reg[i] <= rt_base_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Weight stage: signed distance and the two clamped coverages
    // ------------------------------------------------------------------
    function automatic logic [WGT_W-1:0] clamp_wgt(input logic signed [SD_W-1:0] t);
        logic [WGT_W-1:0] w;
        if (t[SD_W-1] || (t == '0))
            w = '0;
        else if (t[SD_W-2:WGT_W-1] != '0)
            w = WGT_ONE;
        else
            w = t[WGT_W-1:0];
        return w;
    endfunction

    logic signed [BASE_W-1:0] sd_base;
    logic signed [SD_W-1:0]   sd;
    logic [WGT_W-1:0]         wo_reg, wi_reg, wo_next, wi_next;

    always_comb
    begin
        sd_base = rt_base_reg[ROOT_W-1];
        sd      = $signed({{2{sd_base[BASE_W-1]}}, sd_base})
                + $signed({3'b0, rt_root_reg[ROOT_W-1]});
        wo_next = clamp_wgt(OUT_OFS - sd);
        wi_next = clamp_wgt(IN_OFS - sd);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            wo_reg <= wo_next;
            wi_reg <= wi_next;
        end
    end

    // ------------------------------------------------------------------
    // Blend stages: background toward border, then toward fill
    // ------------------------------------------------------------------
    logic [COLOR_W-1:0] mix1_reg, mix1_next, mix2;
    logic [WGT_W-1:0]   wi1_reg;
    logic [31:0]        pix_reg, pix_next;

    assign mix1_next = blend_rgb(back_color_reg, border_color_reg, wo_reg);
    assign mix2      = blend_rgb(mix1_reg, fill_color_reg, wi1_reg);
    assign pix_next  = {ALPHA_OPAQUE, mix2[7:0], mix2[15:8], mix2[23:16]};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mix1_reg <= mix1_next;
            wi1_reg  <= wi_reg;
            pix_reg  <= pix_next;
        end
    end

    // ------------------------------------------------------------------
    // Two-entry output buffer
    // ------------------------------------------------------------------
    logic [31:0] buf_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;

    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_ptr_reg] <= pix_reg;
    end

    assign out_valid  = (cnt_reg != 2'd0);
    assign pixel_word = buf_reg[rd_ptr_reg];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) && !out_ready |=> vld_reg == $past(vld_reg))
        else $error("pipeline moved while output buffer was full");

    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_WGT-1] |-> rt_rem_reg[ROOT_W-1] <= {1'b0, rt_root_reg[ROOT_W-1], 1'b0})
        else $error("square root remainder exceeds bound");

    a_fill_implies_border: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_WGT] && (wi_reg != '0) |-> wo_reg == WGT_ONE)
        else $error("fill coverage without full outer coverage");

endmodule
